/* design/thsup_pkg.sv */
// Package for the thermal supervisor: field widths, fixed-point constants,
// register indexes, status codes and the ADC code conversion.
// No dependencies.
`default_nettype none

package thsup_pkg;

  localparam int CHECK_PERIOD = 12;
  localparam int PHASE_W      = 4;

  localparam int TEMP_W = 16;
  localparam int REF_W  = 15;
  localparam int CODE_W = 16;
  localparam int PWR_W  = 8;
  localparam int DAC_W  = 16;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;

  // raw conversion result, wide enough before plausibility replacement
  localparam int RAW_W  = 18;
  localparam int DIFF_W = 19;

  localparam logic signed [DIFF_W-1:0] VCO_DEV   = 19'sd1500;
  localparam logic signed [DIFF_W-1:0] PA_DEV_LO = 19'sd1000;
  localparam logic signed [DIFF_W-1:0] PA_DEV_HI = 19'sd2000;
  localparam logic signed [TEMP_W-1:0] VCO_SUB   = 16'sd1;
  localparam logic signed [TEMP_W-1:0] PA_SUB    = 16'sd501;
  localparam logic signed [18:0]       KELVIN_OFS = 19'sd27315;

  localparam int ACC_W = 29;
  localparam logic signed [ACC_W-1:0] DAC_OFS  = 29'sd170790925;
  localparam logic signed [11:0]      DAC_GAIN = 12'sd1072;

  localparam logic signed [TEMP_W-1:0] HIGH_TEMP_RST = 16'sd6000;
  localparam logic signed [TEMP_W-1:0] LOW_TEMP_RST  = 16'sd5000;
  localparam logic [PWR_W-1:0]         PA_MASK_RST   = 8'd7;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_HIGH_TEMP = 2'd0,
    REG_LOW_TEMP  = 2'd1,
    REG_PA_MASK   = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_SHUT     = 3'd0,
    ST_RESTORED = 3'd1,
    ST_HOT      = 3'd2,
    ST_HOT_OFF  = 3'd3,
    ST_COLD     = 3'd4,
    ST_NORMAL   = 3'd5
  } status_t;

  // floor(code*5/4) - 27315, in hundredths of a degree
  function automatic logic signed [RAW_W-1:0] code_to_temp(
      input logic signed [CODE_W-1:0] code);
    logic signed [18:0] p5;
    logic signed [18:0] t;
    p5 = (19'(code) <<< 2) + 19'(code);
    t  = (p5 >>> 2) - KELVIN_OFS;
    return t[RAW_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* design/thsup_if.sv */
// Handshake channels of the thermal supervisor: sample input, result output
// and register write. Depends on thsup_pkg.
`default_nettype none

interface thsup_in_if;
  import thsup_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [CODE_W-1:0] vco_code;
  logic signed [CODE_W-1:0] pa_code;
  logic signed [REF_W-1:0]  ref_temp;
  logic [PWR_W-1:0]         power_in;

  modport source (output valid, vco_code, pa_code, ref_temp, power_in, input ready);
  modport sink   (input valid, vco_code, pa_code, ref_temp, power_in, output ready);
endinterface

interface thsup_out_if;
  import thsup_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [TEMP_W-1:0] vco_temp;
  logic signed [TEMP_W-1:0] pa_temp;
  logic [PWR_W-1:0]         power_out;
  logic                     power_write;
  logic [DAC_W-1:0]         dac_word;
  logic                     dac_write;
  logic                     pa_off;
  logic [2:0]               status;

  modport source (output valid, vco_temp, pa_temp, power_out, power_write, dac_word,
                  dac_write, pa_off, status, input ready);
  modport sink   (input valid, vco_temp, pa_temp, power_out, power_write, dac_word,
                  dac_write, pa_off, status, output ready);
endinterface

interface thsup_cfg_if;
  import thsup_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

`default_nettype wire

/* design/thermal_supervisor_hysteresis.sv */
// Thermal supervisor with PA shutdown hysteresis and VCO DAC tracking.
// Depends on thsup_pkg and the channels in thsup_if.
//
// One sample is taken per cycle unless the result side stalls. A transfer
// lands in an input register; the conversion, plausibility checks,
// shutdown/restore decision and DAC word are worked out in one pass of logic
// and captured in the result register, so the block sustains one sample per
// clock while the result side keeps up. The slowest path is the code
// conversion, replacement mux and the 16x12 DAC multiply. The tick
// counter, the off flag and the last DAC word advance when a sample passes
// into the result register. Register writes are always taken and are meant
// to arrive while no sample is in flight; writes to unused indexes are dropped.
`default_nettype none

module thermal_supervisor_hysteresis (
  input  wire logic  clk,
  input  wire logic  rst,
  thsup_in_if.sink   sample,
  thsup_out_if.source result,
  thsup_cfg_if.sink  cfg
);
  import thsup_pkg::*;

  // configuration
  logic signed [TEMP_W-1:0] high_temp;
  logic signed [TEMP_W-1:0] low_temp;
  logic [PWR_W-1:0]         pa_mask;

  // state
  logic [PHASE_W-1:0] check_phase;
  logic [PHASE_W-1:0] check_phase_next;
  logic               off_flag;
  logic               off_flag_next;
  logic [DAC_W-1:0]   last_dac;

  // input register
  logic                     s1_valid;
  logic signed [CODE_W-1:0] s1_vco_code;
  logic signed [CODE_W-1:0] s1_pa_code;
  logic signed [REF_W-1:0]  s1_ref;
  logic [PWR_W-1:0]         s1_power;

  logic advance;
  logic s1_move;

  // datapath
  logic signed [RAW_W-1:0]  vco_raw;
  logic signed [RAW_W-1:0]  pa_raw;
  logic signed [DIFF_W-1:0] vco_diff;
  logic signed [DIFF_W-1:0] pa_diff;
  logic signed [TEMP_W-1:0] ref_ext;
  logic signed [TEMP_W-1:0] vco_chk;
  logic signed [TEMP_W-1:0] pa_chk;
  logic                     due;
  logic [PWR_W-1:0]         power_next;
  logic                     pwr_wr;
  status_t                  status_next;
  logic signed [27:0]       dac_prod;
  logic signed [ACC_W-1:0]  dac_acc;
  logic [DAC_W-1:0]         dac_next;

  assign advance      = !result.valid || result.ready;
  assign s1_move      = s1_valid && advance;
  assign sample.ready = !s1_valid || advance;
  assign cfg.ready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      high_temp <= HIGH_TEMP_RST;
      low_temp  <= LOW_TEMP_RST;
      pa_mask   <= PA_MASK_RST;
    end else if (cfg.valid) begin
      case (cfg.addr)
        REG_HIGH_TEMP: high_temp <= cfg.data;
        REG_LOW_TEMP:  low_temp  <= cfg.data;
        REG_PA_MASK:   pa_mask   <= cfg.data[PWR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sample.ready) begin
      s1_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      s1_vco_code <= sample.vco_code;
      s1_pa_code  <= sample.pa_code;
      s1_ref      <= sample.ref_temp;
      s1_power    <= sample.power_in;
    end
  end

  always_comb begin
    if (check_phase == PHASE_W'(CHECK_PERIOD - 1)) begin
      check_phase_next = '0;
    end else begin
      check_phase_next = check_phase + PHASE_W'(1);
    end
    due = (check_phase_next == '0);

    vco_raw  = code_to_temp(s1_vco_code);
    pa_raw   = code_to_temp(s1_pa_code);
    ref_ext  = TEMP_W'(s1_ref);
    vco_diff = DIFF_W'(s1_ref) - DIFF_W'(vco_raw);
    pa_diff  = DIFF_W'(s1_ref) - DIFF_W'(pa_raw);

    // implausible readings fall back to just above the CPU temperature
    if (vco_diff > VCO_DEV || vco_diff < -VCO_DEV) begin
      vco_chk = ref_ext + VCO_SUB;
    end else begin
      vco_chk = vco_raw[TEMP_W-1:0];
    end
    if (pa_diff > PA_DEV_LO || pa_diff < -PA_DEV_HI) begin
      pa_chk = ref_ext + PA_SUB;
    end else begin
      pa_chk = pa_raw[TEMP_W-1:0];
    end

    power_next    = s1_power;
    pwr_wr        = 1'b0;
    off_flag_next = off_flag;
    if (pa_chk > high_temp && due) begin
      power_next    = s1_power & ~pa_mask;
      pwr_wr        = 1'b1;
      off_flag_next = 1'b1;
      status_next   = ST_SHUT;
    end else if (pa_chk < low_temp && off_flag) begin
      power_next    = s1_power | pa_mask;
      pwr_wr        = 1'b1;
      off_flag_next = 1'b0;
      status_next   = ST_RESTORED;
    end else if (pa_chk > low_temp) begin
      status_next = off_flag ? ST_HOT_OFF : ST_HOT;
    end else if (pa_chk < 0) begin
      status_next = ST_COLD;
    end else begin
      status_next = ST_NORMAL;
    end

    // over the 16-bit temperature range the sum stays between 0 and 2^28, so
    // the negative clamp never applies
    dac_prod = 28'(vco_chk) * 28'(DAC_GAIN);
    dac_acc  = DAC_OFS + ACC_W'(dac_prod);
    if (dac_acc[ACC_W-1]) begin
      dac_next = '0;
    end else begin
      dac_next = DAC_W'(dac_acc[ACC_W-2:16]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      check_phase  <= '0;
      off_flag     <= 1'b0;
      last_dac     <= '0;
      result.valid <= 1'b0;
    end else if (advance) begin
      result.valid <= s1_valid;
      if (s1_move) begin
        check_phase <= check_phase_next;
        off_flag    <= off_flag_next;
        last_dac    <= dac_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      result.vco_temp    <= vco_chk;
      result.pa_temp     <= pa_chk;
      result.power_out   <= power_next;
      result.power_write <= pwr_wr;
      result.dac_word    <= dac_next;
      result.dac_write   <= (dac_next != last_dac);
      result.pa_off      <= off_flag_next;
      result.status      <= status_next;
    end
  end

endmodule

`default_nettype wire
